// ----- hw/rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int MAX_BYTES_DEF = 255;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [3:0]  RETRIES_RST     = 4'd10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES     = 1'b1;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] ADDR10_HDR  = 8'hF0;
    localparam logic [7:0] ADDR10_MASK = 8'h06;
    localparam logic [7:0] ADDR_RD_BIT = 8'h01;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_ADDR_NACK = 2'd1;
    localparam logic [1:0] STS_DATA_NACK = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_DESC = 2'd1,
        KIND_BYTE = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] position;
        logic       no_read_ack;
        logic       no_stop;
        logic       no_start;
        logic       ignore_nack;
        logic       ten_bit;
        logic       is_read;
        logic [7:0] length;
        logic [9:0] address;
    } t_desc;

    typedef struct packed {
        t_kind      kind;
        logic       sda_in;
        t_desc      desc;
        logic [7:0] write_byte;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       byte_request;
        logic       message_done;
        logic       transfer_done;
        logic [1:0] status;
        logic [7:0] messages_done;
        logic       busy_res;
    } t_res;

endpackage

// ----- hw/rtl/i2cms_front.sv -----
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts stream items, classifies them by kind and queues them.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  t_cmd       i_cmd,
    output logic       o_q_valid,
    output t_cmd       o_q_cmd,
    input  logic       i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_kind            kind;
    t_cmd             cmd_in;
    logic             push;

    always_comb begin
        case (i_action)
            2'd0:    kind = KIND_TICK;
            2'd1:    kind = KIND_DESC;
            2'd2:    kind = KIND_BYTE;
            default: kind = KIND_NONE;
        endcase
        cmd_in      = i_cmd;
        cmd_in.kind = kind;
    end

    assign o_ready   = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push) - CNT_W'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hw/rtl/i2cms_back.sv -----
// ----------------------------------------------------------------------------
// i2cms_back
// Bus sequencer: runs queued items against the SCL/SDA phase machine and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_half_period,
    input  logic [3:0]  i_retries,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_m_valid,
    input  logic        i_m_ready,
    output t_res        o_m_res
);

    typedef enum logic [26:0] {
        PH_IDLE    = 27'd1 << 0,
        PH_WAITB   = 27'd1 << 1,
        PH_BEGIN   = 27'd1 << 2,
        PH_WAIT    = 27'd1 << 3,
        PH_ST1     = 27'd1 << 4,
        PH_ST2     = 27'd1 << 5,
        PH_RS1     = 27'd1 << 6,
        PH_RS2     = 27'd1 << 7,
        PH_RS3     = 27'd1 << 8,
        PH_SP1     = 27'd1 << 9,
        PH_SP2     = 27'd1 << 10,
        PH_SP3     = 27'd1 << 11,
        PH_SPDONE  = 27'd1 << 12,
        PH_WB1     = 27'd1 << 13,
        PH_WB2     = 27'd1 << 14,
        PH_WB3     = 27'd1 << 15,
        PH_WB4     = 27'd1 << 16,
        PH_WB5     = 27'd1 << 17,
        PH_WB6     = 27'd1 << 18,
        PH_WB7     = 27'd1 << 19,
        PH_RB1     = 27'd1 << 20,
        PH_RB2     = 27'd1 << 21,
        PH_RB3     = 27'd1 << 22,
        PH_RBDONE  = 27'd1 << 23,
        PH_AK1     = 27'd1 << 24,
        PH_AK2     = 27'd1 << 25,
        PH_AK3     = 27'd1 << 26
    } t_phase;

    typedef enum logic [3:0] {
        STG_A1   = 4'b0001,
        STG_A2   = 4'b0010,
        STG_A3   = 4'b0100,
        STG_DATA = 4'b1000
    } t_stage;

    function automatic logic [7:0] addr_byte(t_stage stg, t_desc d);
        logic [7:0] b;
        if (stg == STG_A2) begin
            b = d.address[7:0];
        end else if (d.ten_bit) begin
            b = ADDR10_HDR | ({5'd0, d.address[9:7]} & ADDR10_MASK);
            if (stg == STG_A3) begin
                b = b | ADDR_RD_BIT;
            end
        end else begin
            b = {d.address[6:0], d.is_read};
        end
        return b;
    endfunction

    t_phase      r_phase, n_phase;
    t_phase      r_after, n_after;
    t_stage      r_stage, n_stage;
    logic [15:0] r_wait, n_wait;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_retry, n_retry;
    logic [7:0]  r_left, n_left;
    t_desc       r_desc, n_desc;
    logic [7:0]  r_msgs, n_msgs;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_stop_final, n_stop_final;
    logic [1:0]  r_status, n_status;
    logic        r_acc_read, r_acc_msg, r_acc_xfer;
    logic        r_ov;
    t_res        r_out, n_out;

    logic        p_read, p_msg, p_xfer;
    logic        transient;
    logic        f_next, f_finish, f_addr_ok, f_enter, f_send;
    logic [1:0]  fin_st;
    logic [7:0]  send_val;
    logic [15:0] s_wait;
    logic [3:0]  eff_retries;
    logic [7:0]  len_clamped;
    logic [3:0]  bit_inc;
    logic        ack;
    logic        slot_free, step, pop;

    assign s_wait      = 16'((17'(i_half_period) + 17'd1) >> 1);
    assign eff_retries = r_desc.ignore_nack ? 4'd0 : ((i_retries == 4'd0) ? 4'd1 : i_retries);
    assign len_clamped = ({8'd0, r_desc.length} > 16'(MAX_BYTES)) ? 8'(MAX_BYTES)
                                                                   : r_desc.length;
    assign bit_inc     = r_bit + 4'd1;
    assign ack         = (r_bit == 4'd1);

    always_comb begin
        n_phase      = r_phase;
        n_after      = r_after;
        n_stage      = r_stage;
        n_wait       = r_wait;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_retry      = r_retry;
        n_left       = r_left;
        n_desc       = r_desc;
        n_msgs       = r_msgs;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_stop_final = r_stop_final;
        n_status     = r_status;
        p_read       = 1'b0;
        p_msg        = 1'b0;
        p_xfer       = 1'b0;
        transient    = 1'b0;
        f_next       = 1'b0;
        f_finish     = 1'b0;
        f_addr_ok    = 1'b0;
        f_enter      = 1'b0;
        f_send       = 1'b0;
        fin_st       = STS_OK;
        send_val     = 8'd0;

        case (i_q_cmd.kind)
            KIND_DESC: begin
                if (r_phase == PH_IDLE) begin
                    n_desc = i_q_cmd.desc;
                    if (i_q_cmd.desc.position[0]) begin
                        n_msgs   = 8'd0;
                        n_status = STS_OK;
                    end
                    n_phase = PH_BEGIN;
                end
            end
            KIND_BYTE: begin
                if (r_phase == PH_WAITB) begin
                    f_send   = 1'b1;
                    send_val = i_q_cmd.write_byte;
                end
            end
            KIND_TICK: begin
                case (r_phase)
                    PH_IDLE, PH_WAITB: begin
                    end
                    PH_BEGIN: begin
                        transient = 1'b1;
                        if (r_desc.no_start) begin
                            f_enter = 1'b1;
                        end else begin
                            n_stage = STG_A1;
                            n_retry = 4'd0;
                            n_phase = r_desc.position[0] ? PH_ST1 : PH_RS1;
                        end
                    end
                    PH_WAIT: begin
                        if (r_wait == 16'd0) begin
                            transient = 1'b1;
                            n_phase   = r_after;
                        end else begin
                            n_wait = r_wait - 16'd1;
                            if (r_wait == 16'd1) begin
                                n_phase = r_after;
                            end
                        end
                    end
                    PH_ST1: begin
                        n_sda = 1'b0; n_wait = s_wait; n_after = PH_ST2; n_phase = PH_WAIT;
                    end
                    PH_ST2: begin
                        n_scl    = 1'b0;
                        f_send   = 1'b1;
                        send_val = addr_byte(r_stage, r_desc);
                    end
                    PH_RS1: begin
                        n_sda = 1'b1; n_phase = PH_RS2;
                    end
                    PH_RS2: begin
                        n_scl = 1'b1; n_wait = s_wait; n_after = PH_RS3; n_phase = PH_WAIT;
                    end
                    PH_RS3: begin
                        n_sda = 1'b0; n_wait = s_wait; n_after = PH_ST2; n_phase = PH_WAIT;
                    end
                    PH_SP1: begin
                        n_sda = 1'b0; n_wait = s_wait; n_after = PH_SP2; n_phase = PH_WAIT;
                    end
                    PH_SP2: begin
                        n_scl = 1'b1; n_wait = s_wait; n_after = PH_SP3; n_phase = PH_WAIT;
                    end
                    PH_SP3: begin
                        n_sda   = 1'b1;
                        n_wait  = i_half_period;
                        n_after = PH_SPDONE;
                        n_phase = PH_WAIT;
                    end
                    PH_SPDONE: begin
                        transient = 1'b1;
                        if (r_stop_final) begin
                            p_xfer  = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_wait  = i_half_period;
                            n_after = PH_ST1;
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_WB1: begin
                        n_scl = 1'b0; n_phase = PH_WB2;
                    end
                    PH_WB2: begin
                        n_sda   = r_shift[r_bit[2:0]];
                        n_wait  = s_wait;
                        n_after = PH_WB3;
                        n_phase = PH_WAIT;
                    end
                    PH_WB3: begin
                        n_scl = 1'b1;
                        if (r_bit[2:0] == 3'd0) begin
                            n_phase = PH_WB4;
                        end else begin
                            n_bit   = {1'b0, r_bit[2:0] - 3'd1};
                            n_phase = PH_WB1;
                        end
                    end
                    PH_WB4: begin
                        n_scl = 1'b0; n_wait = s_wait; n_after = PH_WB5; n_phase = PH_WAIT;
                    end
                    PH_WB5: begin
                        n_sda = 1'b1; n_wait = s_wait; n_after = PH_WB6; n_phase = PH_WAIT;
                    end
                    PH_WB6: begin
                        n_scl   = 1'b1;
                        n_bit   = i_q_cmd.sda_in ? 4'd0 : 4'd1;
                        n_phase = PH_WB7;
                    end
                    PH_WB7: begin
                        n_scl = 1'b0;
                        if (r_stage == STG_DATA) begin
                            if (ack || r_desc.ignore_nack) begin
                                n_left = r_left - 8'd1;
                                f_next = 1'b1;
                            end else begin
                                f_finish = 1'b1;
                                fin_st   = STS_DATA_NACK;
                            end
                        end else if (r_stage == STG_A2) begin
                            if (ack || r_desc.ignore_nack) begin
                                f_addr_ok = 1'b1;
                            end else begin
                                f_finish = 1'b1;
                                fin_st   = STS_ADDR_NACK;
                            end
                        end else if (ack) begin
                            f_addr_ok = 1'b1;
                        end else if (r_retry >= eff_retries) begin
                            if (r_desc.ignore_nack) begin
                                f_addr_ok = 1'b1;
                            end else begin
                                f_finish = 1'b1;
                                fin_st   = STS_ADDR_NACK;
                            end
                        end else begin
                            n_retry      = r_retry + 4'd1;
                            n_stop_final = 1'b0;
                            n_phase      = PH_SP1;
                        end
                    end
                    PH_RB1: begin
                        n_sda   = 1'b1;
                        n_bit   = 4'd0;
                        n_wait  = s_wait;
                        n_after = PH_RB2;
                        n_phase = PH_WAIT;
                    end
                    PH_RB2: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], i_q_cmd.sda_in};
                        n_phase = PH_RB3;
                    end
                    PH_RB3: begin
                        n_scl   = 1'b0;
                        n_bit   = bit_inc;
                        n_wait  = i_half_period;
                        n_after = (bit_inc >= 4'd8) ? PH_RBDONE : PH_RB2;
                        n_phase = PH_WAIT;
                    end
                    PH_RBDONE: begin
                        transient = 1'b1;
                        p_read    = 1'b1;
                        n_left    = r_left - 8'd1;
                        if (r_desc.no_read_ack) begin
                            f_next = 1'b1;
                        end else if (n_left != 8'd0) begin
                            n_phase = PH_AK1;
                        end else begin
                            n_wait  = s_wait;
                            n_after = PH_AK2;
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_AK1: begin
                        n_sda = 1'b0; n_wait = s_wait; n_after = PH_AK2; n_phase = PH_WAIT;
                    end
                    PH_AK2: begin
                        n_scl = 1'b1; n_phase = PH_AK3;
                    end
                    PH_AK3: begin
                        n_scl  = 1'b0;
                        f_next = 1'b1;
                    end
                    default: begin
                        transient = 1'b1;
                        n_phase   = PH_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (f_addr_ok) begin
            if (r_stage == STG_A1 && r_desc.ten_bit) begin
                n_stage  = STG_A2;
                f_send   = 1'b1;
                send_val = addr_byte(STG_A2, r_desc);
            end else if (r_stage == STG_A2 && r_desc.is_read) begin
                n_stage = STG_A3;
                n_retry = 4'd0;
                n_phase = PH_RS1;
            end else begin
                f_enter = 1'b1;
            end
        end
        if (f_enter) begin
            n_stage = STG_DATA;
            n_left  = len_clamped;
            f_next  = 1'b1;
        end
        if (f_next) begin
            if (n_left == 8'd0) begin
                p_msg = 1'b1;
                if (r_msgs != 8'hFF) begin
                    n_msgs = r_msgs + 8'd1;
                end
                if (r_desc.position[1]) begin
                    f_finish = 1'b1;
                    fin_st   = STS_OK;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else if (r_desc.is_read) begin
                n_phase = PH_RB1;
            end else begin
                n_phase = PH_WAITB;
            end
        end
        if (f_finish) begin
            n_status = fin_st;
            if (!r_desc.no_stop) begin
                n_stop_final = 1'b1;
                n_phase      = PH_SP1;
            end else begin
                p_xfer  = 1'b1;
                n_phase = PH_IDLE;
            end
        end
        if (f_send) begin
            n_shift = send_val;
            n_bit   = 4'd7;
            n_phase = PH_WB1;
        end
    end

    always_comb begin
        n_out.scl_out       = n_scl;
        n_out.sda_out       = n_sda;
        n_out.read_valid    = r_acc_read | p_read;
        n_out.read_byte     = n_out.read_valid ? n_shift : 8'd0;
        n_out.byte_request  = (n_phase == PH_WAITB);
        n_out.message_done  = r_acc_msg | p_msg;
        n_out.transfer_done = r_acc_xfer | p_xfer;
        n_out.status        = n_out.transfer_done ? n_status : STS_OK;
        n_out.messages_done = n_msgs;
        n_out.busy_res      = (n_phase != PH_IDLE);
    end

    assign slot_free = !r_ov || i_m_ready;
    assign step      = i_q_valid && (transient || slot_free);
    assign pop       = i_q_valid && !transient && slot_free;
    assign o_q_pop   = pop;
    assign o_m_valid = r_ov;
    assign o_m_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_after      <= PH_IDLE;
            r_stage      <= STG_A1;
            r_wait       <= '0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_retry      <= '0;
            r_left       <= '0;
            r_desc       <= '0;
            r_msgs       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_stop_final <= 1'b0;
            r_status     <= STS_OK;
            r_acc_read   <= 1'b0;
            r_acc_msg    <= 1'b0;
            r_acc_xfer   <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (step) begin
                r_phase      <= n_phase;
                r_after      <= n_after;
                r_stage      <= n_stage;
                r_wait       <= n_wait;
                r_bit        <= n_bit;
                r_shift      <= n_shift;
                r_retry      <= n_retry;
                r_left       <= n_left;
                r_desc       <= n_desc;
                r_msgs       <= n_msgs;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_stop_final <= n_stop_final;
                r_status     <= n_status;
                r_acc_read   <= transient && (r_acc_read | p_read);
                r_acc_msg    <= transient && (r_acc_msg | p_msg);
                r_acc_xfer   <= transient && (r_acc_xfer | p_xfer);
            end
            if (pop) begin
                r_ov <= 1'b1;
            end else if (i_m_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !(step && i_q_cmd.kind == KIND_DESC)) |=> r_phase == PH_IDLE)
        else $error("sequencer left idle without a descriptor");

    a_acc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_read || r_acc_msg || r_acc_xfer) |-> i_q_valid)
        else $error("pulses held with no pending tick");

    a_waitbyte_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAITB) |-> (r_stage == STG_DATA && !r_desc.is_read))
        else $error("byte request outside a write data phase");

    a_wb_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WB1 || r_phase == PH_WB2 || r_phase == PH_WB3) |-> r_bit < 4'd8)
        else $error("write bit index out of range");
`endif

endmodule

// ----- hw/rtl/i2c_master_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_sequencer_unit
// Tick-driven I2C master: descriptors, write bytes and SDA-sampled ticks in,
// one status word with the SCL/SDA drive levels out for every item.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result word. Descriptor, write-byte
// and most tick items flow back to back while the result register can take a
// new word. A tick that lands on an internal bookkeeping phase (message begin,
// zero-length wait, end of stop, end of read byte) stays at the head of the
// queue while the single-step phase sequencer in the back end passes each such
// phase. A four-entry queue separates input acceptance from the sequencer,
// and a result register holds the output word. Configuration writes are
// accepted every cycle.
module i2c_master_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sda_in[0], position[2:1], message_address[12:3], message_length[20:13],
    // is_read[21], ten_bit[22], ignore_nack[23], no_start[24], no_stop[25],
    // no_read_ack[26], write_byte[34:27], zero[39:35]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scl_out[0], sda_out[1], read_byte[9:2], read_valid[10], byte_request[11],
    // message_done[12], transfer_done[13], status[15:14], messages_done[23:16],
    // busy_res[24], zero[31:25]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_half_period;
    logic [3:0]  r_retries;
    t_cmd        cmd_in;
    t_cmd        q_cmd;
    logic        q_valid, q_pop;
    t_res        res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_retries     <= RETRIES_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data[15:0];
                CFG_RETRIES:     r_retries     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cmd_in.kind             = KIND_NONE;
        cmd_in.sda_in           = s_axis_tdata[0];
        cmd_in.desc.position    = s_axis_tdata[2:1];
        cmd_in.desc.address     = s_axis_tdata[12:3];
        cmd_in.desc.length      = s_axis_tdata[20:13];
        cmd_in.desc.is_read     = s_axis_tdata[21];
        cmd_in.desc.ten_bit     = s_axis_tdata[22];
        cmd_in.desc.ignore_nack = s_axis_tdata[23];
        cmd_in.desc.no_start    = s_axis_tdata[24];
        cmd_in.desc.no_stop     = s_axis_tdata[25];
        cmd_in.desc.no_read_ack = s_axis_tdata[26];
        cmd_in.write_byte       = s_axis_tdata[34:27];
    end

    i2cms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_cmd     (cmd_in),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    i2cms_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_half_period),
        .i_retries     (r_retries),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_res       (res)
    );

    assign m_axis_tdata = {7'd0, res.busy_res, res.messages_done, res.status,
                           res.transfer_done, res.message_done, res.byte_request,
                           res.read_valid, res.read_byte, res.sda_out, res.scl_out};

endmodule
